// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the expression holds at every clock edge outside reset.
`define CHK_ALWAYS(label, clk_sig, rst_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHK_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/frf_pkg.sv -----
// Shared types and constants of the frame replay filter.
package frf_pkg;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_POLL  = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] MK_DATA = 2'd0;
  localparam logic [1:0] MK_BEAT = 2'd1;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_ONLINE  = 2'd1;
  localparam logic [1:0] KIND_LOAD    = 2'd2;
  localparam logic [1:0] KIND_POLL    = 2'd3;

  localparam logic [2:0] VERD_NONE    = 3'd0;
  localparam logic [2:0] VERD_NOTOURS = 3'd4;
  localparam logic [2:0] VERD_BLOCKED = 3'd5;
  localparam logic [2:0] VERD_REPLAY  = 3'd6;

  localparam logic [2:0] REG_ROLE    = 3'd0;
  localparam logic [2:0] REG_LOCAL   = 3'd1;
  localparam logic [2:0] REG_BCAST   = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_HOLD    = 3'd4;

  localparam logic [31:0] DEFAULT_BEAT_TIMEOUT = 32'd3000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_DECIDE, ST_VERDICT, ST_POLL, ST_PDONE, ST_LOAD
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan_step;
    logic frame_do;
    logic verdict_do;
    logic poll_step;
    logic poll_done;
    logic load_do;
  } cmd_t;

  typedef struct packed {
    logic [1:0] code;
    logic       scan_last;
    logic       dev_last;
    logic       frame_two;
    logic       poll_hit;
    logic       out_free;
  } stat_t;

endpackage

// ----- design/frf_ctrl.sv -----
// Controller state machine of the frame replay filter.
module frf_ctrl import frf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (stat.code == CMD_FRAME) state_next = ST_SCAN;
        else if (stat.code == CMD_POLL) state_next = ST_POLL;
        else if (stat.code == CMD_LOAD) state_next = ST_LOAD;
        else state_next = ST_IDLE;
      end
      ST_SCAN: if (stat.scan_last) state_next = ST_DECIDE;
      ST_DECIDE: if (stat.out_free) state_next = stat.frame_two ? ST_VERDICT : ST_IDLE;
      ST_VERDICT: if (stat.out_free) state_next = ST_IDLE;
      ST_POLL: if (stat.dev_last && (!stat.poll_hit || stat.out_free)) state_next = ST_PDONE;
      ST_PDONE: if (stat.out_free) state_next = ST_IDLE;
      ST_LOAD: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.latch = in_valid;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DECIDE: cmd.frame_do = stat.out_free;
      ST_VERDICT: cmd.verdict_do = stat.out_free;
      ST_POLL: cmd.poll_step = !stat.poll_hit || stat.out_free;
      ST_PDONE: cmd.poll_done = stat.out_free;
      ST_LOAD: cmd.load_do = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/frf_dp.sv -----
// Datapath of the frame replay filter: tables, scan, output register.
module frf_dp import frf_pkg::*; #(
  parameter int MAX_DEVICES = 8,
  parameter int MAX_BLOCKED = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  command,
  input  logic [31:0] now,
  input  logic [7:0]  frame_src,
  input  logic [7:0]  frame_dst,
  input  logic [15:0] seq_num,
  input  logic [1:0]  msg_kind,
  input  logic [2:0]  slot,
  input  logic        paired,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  verdict,
  output logic [7:0]  addr,
  output logic        online,
  output logic        last,
  input  cmd_t        cmd,
  output stat_t       stat
);

  localparam int SCAN_N = (MAX_DEVICES > MAX_BLOCKED) ? MAX_DEVICES : MAX_BLOCKED;
  localparam int SW = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int BW = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;

  logic        role_master;
  logic [7:0]  local_address, broadcast_address;
  logic [31:0] beat_timeout, blacklist_hold;

  logic [1:0]  c_cmd;
  logic [31:0] c_now;
  logic [7:0]  c_src, c_dest;
  logic [15:0] c_seq;
  logic [1:0]  c_mk;
  logic [2:0]  c_slot;
  logic        c_paired;

  logic        dev_valid [MAX_DEVICES];
  logic [7:0]  dev_address [MAX_DEVICES];
  logic        dev_paired [MAX_DEVICES];
  logic [15:0] dev_expected_seq [MAX_DEVICES];
  logic        dev_online [MAX_DEVICES];
  logic [31:0] dev_last_beat [MAX_DEVICES];
  logic        block_valid [MAX_BLOCKED];
  logic [7:0]  block_address [MAX_BLOCKED];
  logic [31:0] block_expire [MAX_BLOCKED];

  logic [SW-1:0] idx;
  logic          blk_hit, free_found, dev_found;
  logic [BW-1:0] free_idx;
  logic [DW-1:0] dev_idx;

  logic [DW-1:0] pidx;
  logic [BW-1:0] bidx;
  logic          dest_ok, replay, beat, frame_two, poll_hit, out_free;
  logic [15:0]   diff;
  logic [31:0]   tmo;

  logic       e_valid, e_online, e_last;
  logic [1:0] e_kind;
  logic [2:0] e_verdict;
  logic [7:0] e_addr;

  assign pidx = idx[DW-1:0];
  assign bidx = idx[BW-1:0];
  assign dest_ok = (c_dest == local_address) || (c_dest == broadcast_address);
  assign diff = c_seq - dev_expected_seq[dev_idx];
  assign replay = dev_found && dev_paired[dev_idx] && diff[15] && (c_mk == MK_DATA);
  assign beat = (c_mk == MK_BEAT) && role_master && dev_found;
  assign frame_two = dest_ok && !blk_hit && !replay && beat && !dev_online[dev_idx];
  assign tmo = (beat_timeout == 32'd0) ? DEFAULT_BEAT_TIMEOUT : beat_timeout;
  assign poll_hit = role_master && dev_valid[pidx] && dev_paired[pidx] && dev_online[pidx]
                    && ((c_now - dev_last_beat[pidx]) > tmo);
  assign out_free = !out_valid || out_ready;

  assign stat.code      = c_cmd;
  assign stat.scan_last = (idx == SW'(SCAN_N - 1));
  assign stat.dev_last  = (idx == SW'(MAX_DEVICES - 1));
  assign stat.frame_two = frame_two;
  assign stat.poll_hit  = poll_hit;
  assign stat.out_free  = out_free;

  // Result selection for whichever step the controller issues this cycle.
  always_comb begin
    e_valid = 1'b0;
    e_kind = KIND_VERDICT;
    e_verdict = VERD_NONE;
    e_addr = c_src;
    e_online = 1'b0;
    e_last = 1'b1;
    if (cmd.frame_do) begin
      e_valid = 1'b1;
      priority if (!dest_ok) e_verdict = VERD_NOTOURS;
      else if (blk_hit) e_verdict = VERD_BLOCKED;
      else if (replay) e_verdict = VERD_REPLAY;
      else if (frame_two) begin
        e_kind = KIND_ONLINE;
        e_online = 1'b1;
        e_last = 1'b0;
      end else e_verdict = {1'b0, c_mk};
    end else if (cmd.verdict_do) begin
      e_valid = 1'b1;
      e_verdict = {1'b0, c_mk};
    end else if (cmd.poll_step && poll_hit) begin
      e_valid = 1'b1;
      e_kind = KIND_ONLINE;
      e_addr = dev_address[pidx];
      e_last = 1'b0;
    end else if (cmd.poll_done) begin
      e_valid = 1'b1;
      e_kind = KIND_POLL;
      e_addr = 8'd0;
    end else if (cmd.load_do) begin
      e_valid = 1'b1;
      e_kind = KIND_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      role_master <= 1'b0;
      local_address <= 8'd0;
      broadcast_address <= 8'd255;
      beat_timeout <= 32'd3000;
      blacklist_hold <= 32'd60000;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_DEVICES; i++) begin
        dev_valid[i] <= 1'b0;
        dev_paired[i] <= 1'b0;
        dev_online[i] <= 1'b0;
      end
      for (int i = 0; i < MAX_BLOCKED; i++) block_valid[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROLE:    role_master <= cfg_data[0];
          REG_LOCAL:   local_address <= cfg_data[7:0];
          REG_BCAST:   broadcast_address <= cfg_data[7:0];
          REG_TIMEOUT: beat_timeout <= cfg_data;
          REG_HOLD:    blacklist_hold <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.latch) begin
        c_cmd <= command;
        c_now <= now;
        c_src <= frame_src;
        c_dest <= frame_dst;
        c_seq <= seq_num;
        c_mk <= msg_kind;
        c_slot <= slot;
        c_paired <= paired;
        idx <= '0;
        blk_hit <= 1'b0;
        free_found <= 1'b0;
        dev_found <= 1'b0;
      end

      if (cmd.scan_step) begin
        if (int'(idx) < MAX_BLOCKED) begin
          if (block_valid[bidx] && block_address[bidx] == c_src) blk_hit <= 1'b1;
          if (!block_valid[bidx] && !free_found) begin
            free_found <= 1'b1;
            free_idx <= bidx;
          end
        end
        if (int'(idx) < MAX_DEVICES && !dev_found && dev_valid[pidx]
            && dev_address[pidx] == c_src) begin
          dev_found <= 1'b1;
          dev_idx <= pidx;
        end
        idx <= idx + 1'b1;
      end

      if (cmd.frame_do && dest_ok && !blk_hit) begin
        if (replay) begin
          if (free_found) begin
            block_valid[free_idx] <= 1'b1;
            block_address[free_idx] <= c_src;
            block_expire[free_idx] <= c_now + blacklist_hold;
          end
        end else begin
          if (dev_found && dev_paired[dev_idx]) dev_expected_seq[dev_idx] <= c_seq + 16'd1;
          if (beat) begin
            dev_last_beat[dev_idx] <= c_now;
            dev_online[dev_idx] <= 1'b1;
          end
        end
      end

      if (cmd.poll_step) begin
        if (poll_hit) dev_online[pidx] <= 1'b0;
        idx <= idx + 1'b1;
      end

      if (cmd.poll_done) begin
        for (int i = 0; i < MAX_BLOCKED; i++)
          if (block_valid[i] && c_now >= block_expire[i]) block_valid[i] <= 1'b0;
      end

      if (cmd.load_do) begin
        for (int i = 0; i < MAX_DEVICES; i++) begin
          if (7'(c_slot) == 7'(i)) begin
            dev_valid[i] <= 1'b1;
            dev_address[i] <= c_src;
            dev_paired[i] <= c_paired;
            dev_expected_seq[i] <= c_seq;
            dev_online[i] <= 1'b0;
            dev_last_beat[i] <= c_now;
          end
        end
      end

      if (e_valid) begin
        out_valid <= 1'b1;
        kind <= e_kind;
        verdict <= e_verdict;
        addr <= e_addr;
        online <= e_online;
        last <= e_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/frame_replay_filter_with_blacklist.sv -----
// Top level of the frame replay filter with source blacklist.
//
// Input transactions (in_valid/in_ready) carry a command: a frame header, a
// poll tick, or a device table load. One transaction is processed at a time;
// in_ready is high only while the controller is idle.
// Output transactions (out_valid/out_ready) carry result items; the final item
// caused by an input transaction has last set.
// A frame header is captured, dispatched, looked up in a walk that covers
// MAX_DEVICES or MAX_BLOCKED entries (whichever is larger) of both tables
// together, and then decided. A heartbeat that brings its device online
// takes a further verdict step for its second result. A poll tick walks the
// device table one entry per cycle, holding on an entry whose offline result
// waits for the receiver, and then purges the blacklist in its done step.
// A load is captured, dispatched and written in its load step.
// The single output register lets the next transaction be accepted while the
// last result still waits. When the receiver stalls, any step that must emit
// a further result waits in place. Reset clears the valid, paired and online
// bits and the blacklist and returns the configuration registers to their
// defaults; no clearing pass runs.
`include "assert_macros.svh"

module frame_replay_filter_with_blacklist import frf_pkg::*; #(
  parameter int MAX_DEVICES = 8,
  parameter int MAX_BLOCKED = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] now,
  input  logic [7:0]  frame_src,
  input  logic [7:0]  frame_dst,
  input  logic [15:0] seq_num,
  input  logic [1:0]  msg_kind,
  input  logic [2:0]  slot,
  input  logic        paired,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  verdict,
  output logic [7:0]  addr,
  output logic        online,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences capture, table walk, decision and result steps.
  frf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the device table, the blacklist and the result register.
  frf_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_BLOCKED (MAX_BLOCKED)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .now       (now),
    .frame_src (frame_src),
    .frame_dst (frame_dst),
    .seq_num   (seq_num),
    .msg_kind  (msg_kind),
    .slot      (slot),
    .paired    (paired),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .verdict   (verdict),
    .addr      (addr),
    .online    (online),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Only one transaction is in flight at a time.
  `CHK_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready,
            "input accepted twice in a row")

  // At most one result-producing step is issued per cycle.
  `CHK_ALWAYS(a_one_emit, clk, rst,
              $onehot0({cmd.frame_do, cmd.verdict_do, cmd.poll_done, cmd.load_do,
                        cmd.poll_step && stat.poll_hit}),
              "two result steps in one cycle")

  // A result step is only issued when the output register can take it.
  `CHK_SAME(a_emit_room, clk, rst,
            cmd.frame_do || cmd.verdict_do || cmd.poll_done || cmd.load_do
            || (cmd.poll_step && stat.poll_hit),
            stat.out_free, "result issued into an occupied output register")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the frame replay filter with source blacklist.
module testbench;
  import frf_pkg::*;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] verdict;
    logic [7:0] addr;
    logic       online;
    logic       last;
  } frame_result_t;

  // Scoreboard: keeps its own copy of the device table, the blacklist and the
  // configuration, predicts the results of each accepted transaction and
  // checks the results that come out against them in order.
  class filter_scoreboard;
    bit        role_master;
    bit [7:0]  local_a;
    bit [7:0]  bcast_a;
    bit [31:0] beat_tmo;
    bit [31:0] hold;
    bit        dv_valid[8];
    bit [7:0]  dv_addr[8];
    bit        dv_paired[8];
    bit [15:0] dv_seq[8];
    bit        dv_online[8];
    bit [31:0] dv_beat[8];
    bit        bl_valid[8];
    bit [7:0]  bl_addr[8];
    bit [31:0] bl_expire[8];
    frame_result_t expected_q[$];
    int errors;
    int checked;

    function new();
      role_master = 0;
      local_a = 8'd0;
      bcast_a = 8'd255;
      beat_tmo = 32'd3000;
      hold = 32'd60000;
      foreach (dv_valid[i]) begin
        dv_valid[i] = 0;
        dv_paired[i] = 0;
        dv_online[i] = 0;
        bl_valid[i] = 0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ROLE:    role_master = val[0];
        REG_LOCAL:   local_a = val[7:0];
        REG_BCAST:   bcast_a = val[7:0];
        REG_TIMEOUT: beat_tmo = val;
        REG_HOLD:    hold = val;
        default: ;
      endcase
    endfunction

    function int find_dev(bit [7:0] a);
      for (int i = 0; i < 8; i++)
        if (dv_valid[i] && dv_addr[i] == a) return i;
      return -1;
    endfunction

    function bit listed(bit [7:0] a);
      for (int i = 0; i < 8; i++)
        if (bl_valid[i] && bl_addr[i] == a) return 1;
      return 0;
    endfunction

    function void push(logic [1:0] k, logic [2:0] v, logic [7:0] a, logic on, logic l);
      frame_result_t r;
      r.kind = k;
      r.verdict = v;
      r.addr = a;
      r.online = on;
      r.last = l;
      expected_q.push_back(r);
    endfunction

    // Predicts the results of one accepted transaction.
    function void note_input(logic [1:0] cmd, logic [31:0] t, logic [7:0] src,
                             logic [7:0] dest, logic [15:0] seq, logic [1:0] mk,
                             logic [2:0] slt, logic pr);
      int idx;
      bit replay;
      bit [15:0] diff;
      bit [31:0] tmo;
      case (cmd)
        CMD_FRAME: begin
          if (dest != local_a && dest != bcast_a) begin
            push(KIND_VERDICT, VERD_NOTOURS, src, 0, 1);
          end else if (listed(src)) begin
            push(KIND_VERDICT, VERD_BLOCKED, src, 0, 1);
          end else begin
            replay = 0;
            idx = find_dev(src);
            if (idx >= 0 && dv_paired[idx]) begin
              diff = seq - dv_seq[idx];
              if (diff[15] && mk == MK_DATA) begin
                replay = 1;
                // A source already listed is not listed twice; a full list
                // simply drops the new violator.
                if (!listed(src)) begin
                  for (int i = 0; i < 8; i++) begin
                    if (!bl_valid[i]) begin
                      bl_valid[i] = 1;
                      bl_addr[i] = src;
                      bl_expire[i] = t + hold;
                      break;
                    end
                  end
                end
              end else begin
                dv_seq[idx] = seq + 16'd1;
              end
            end
            if (replay) begin
              push(KIND_VERDICT, VERD_REPLAY, src, 0, 1);
            end else begin
              if (mk == MK_BEAT && role_master && idx >= 0) begin
                dv_beat[idx] = t;
                if (!dv_online[idx]) push(KIND_ONLINE, VERD_NONE, src, 1, 0);
                dv_online[idx] = 1;
              end
              push(KIND_VERDICT, {1'b0, mk}, src, 0, 1);
            end
          end
        end
        CMD_POLL: begin
          tmo = (beat_tmo != 0) ? beat_tmo : DEFAULT_BEAT_TIMEOUT;
          if (role_master) begin
            for (int i = 0; i < 8; i++) begin
              if (dv_valid[i] && dv_paired[i] && dv_online[i] && (t - dv_beat[i]) > tmo) begin
                dv_online[i] = 0;
                push(KIND_ONLINE, VERD_NONE, dv_addr[i], 0, 0);
              end
            end
          end
          // Expiry is a plain unsigned compare with no wrap handling.
          for (int i = 0; i < 8; i++)
            if (bl_valid[i] && t >= bl_expire[i]) bl_valid[i] = 0;
          push(KIND_POLL, VERD_NONE, 8'd0, 0, 1);
        end
        CMD_LOAD: begin
          dv_valid[slt] = 1;
          dv_addr[slt] = src;
          dv_paired[slt] = pr;
          dv_seq[slt] = seq;
          dv_online[slt] = 0;
          dv_beat[slt] = t;
          push(KIND_LOAD, VERD_NONE, src, 0, 1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(frame_result_t got);
      frame_result_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result kind %0d addr %0h with nothing expected",
                         got.kind, got.addr));
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind !== exp_r.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, exp_r.kind));
        if (got.verdict !== exp_r.verdict)
          report($sformatf("verdict %0d, expected %0d", got.verdict, exp_r.verdict));
        if (got.addr !== exp_r.addr)
          report($sformatf("addr %0h, expected %0h", got.addr, exp_r.addr));
        if (got.online !== exp_r.online)
          report($sformatf("online %0b, expected %0b", got.online, exp_r.online));
        if (got.last !== exp_r.last)
          report($sformatf("last %0b, expected %0b", got.last, exp_r.last));
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 24;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [31:0] now = '0;
  logic [7:0]  frame_src = '0;
  logic [7:0]  frame_dst = '0;
  logic [15:0] seq_num = '0;
  logic [1:0]  msg_kind = '0;
  logic [2:0]  slot = '0;
  logic        paired = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  kind;
  logic [2:0]  verdict;
  logic [7:0]  addr;
  logic        online;
  logic        last;

  filter_scoreboard sb = new();
  bit quiet = 0;          // when set, neither side inserts idle cycles
  int accepted_items = 0;
  int idle_count = 0;
  bit [31:0] clock_ticks = 0;
  bit [7:0] pool[6];

  frame_replay_filter_with_blacklist u_dut (.*);

  always #5 clk = ~clk;

  // Every output transaction is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result({kind, verdict, addr, online, last});
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_count);
      $display("[frame_replay_filter_with_blacklist] ERROR");
      $finish;
    end
  end

  // Receiver: inserts a random stall before each result unless quiet is set.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 0;
      end
      @(negedge clk);
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Waits until every expected result has arrived, then lets the block drain.
  task drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task send(logic [1:0] cmd, logic [31:0] t, logic [7:0] src, logic [7:0] dest,
            logic [15:0] seq, logic [1:0] mk, logic [2:0] slt, logic pr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_valid <= 1;
    command <= cmd;
    now <= t;
    frame_src <= src;
    frame_dst <= dest;
    seq_num <= seq;
    msg_kind <= mk;
    slot <= slt;
    paired <= pr;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, t, src, dest, seq, mk, slt, pr);
    accepted_items++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  // One random transaction, mostly well-formed traffic from a small set of
  // known sources so that sequence tracking, replays and the blacklist fill up.
  task random_item();
    int sel, idx;
    logic [7:0] src, dest;
    logic [15:0] seq;
    logic [1:0] mk;
    bit [31:0] step;
    sel = $urandom_range(0, 99);
    src = ($urandom_range(0, 99) < 88) ? pool[$urandom_range(0, 5)] : 8'($urandom);
    case ($urandom_range(0, 9))
      0: step = $urandom;
      1, 2: step = (sb.beat_tmo > 32'd100000) ? $urandom_range(0, 5000) : sb.beat_tmo + 32'd1;
      default: step = $urandom_range(0, 40);
    endcase
    clock_ticks += step;
    if (sel < 62) begin
      case ($urandom_range(0, 19))
        0, 1, 2: dest = 8'($urandom);
        3, 4, 5, 6, 7, 8, 9, 10, 11: dest = sb.local_a;
        default: dest = sb.bcast_a;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mk = MK_DATA;
        4, 5, 6: mk = MK_BEAT;
        default: mk = 2'($urandom);
      endcase
      idx = sb.find_dev(src);
      if (idx >= 0 && $urandom_range(0, 9) < 8)
        seq = sb.dv_seq[idx] + 16'($urandom_range(0, 8)) - 16'd3;
      else
        seq = 16'($urandom);
      send(CMD_FRAME, clock_ticks, src, dest, seq, mk, 3'($urandom), 1'($urandom));
    end else if (sel < 82) begin
      send(CMD_POLL, clock_ticks, 8'($urandom), 8'($urandom), 16'($urandom),
           2'($urandom), 3'($urandom), 1'($urandom));
    end else begin
      send(CMD_LOAD, clock_ticks, src, 8'($urandom), 16'($urandom), 2'($urandom),
           3'($urandom), ($urandom_range(0, 3) != 0));
    end
  endtask

  task random_phase(int count);
    foreach (pool[i]) pool[i] = 8'($urandom);
    pool[0] = 8'h00;
    pool[1] = 8'hFF;
    for (int i = 0; i < count; i++) begin
      quiet = (i % 40) >= 32;
      if (i == count / 2) drain();   // sender holds back until the block is empty
      random_item();
    end
    quiet = 0;
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;

    // Directed part in reset configuration: slave role, local 0, broadcast 255.
    send(CMD_LOAD, 32'd0, 8'h10, 8'h00, 16'hFFFF, 2'd0, 3'd0, 1);
    send(CMD_LOAD, 32'd0, 8'hFF, 8'h00, 16'h0000, 2'd0, 3'd7, 0);
    send(CMD_LOAD, 32'd0, 8'h00, 8'h00, 16'h8000, 2'd0, 3'd3, 1);
    send(CMD_FRAME, 32'd5, 8'hFF, 8'h55, 16'h1234, MK_DATA, 3'd0, 0);   // not ours
    send(CMD_FRAME, 32'd6, 8'h10, 8'h00, 16'hFFFF, MK_DATA, 3'd0, 0);   // in order, wraps
    send(CMD_FRAME, 32'd7, 8'h10, 8'hFF, 16'hFFF0, MK_DATA, 3'd0, 0);   // replay
    send(CMD_FRAME, 32'd8, 8'h10, 8'h00, 16'h0000, MK_BEAT, 3'd0, 0);   // now blocked
    send(CMD_FRAME, 32'd9, 8'h00, 8'h00, 16'h7FFF, MK_DATA, 3'd0, 0);   // one behind, replay
    send(CMD_FRAME, 32'd9, 8'h00, 8'h00, 16'h7FFF, 2'd2, 3'd0, 0);      // blocked pairing
    send(CMD_FRAME, 32'd10, 8'hFF, 8'hFF, 16'hFFFF, MK_DATA, 3'd0, 0);  // unpaired source
    send(CMD_FRAME, 32'd11, 8'h42, 8'h00, 16'h0000, 2'd2, 3'd0, 0);     // unknown, pairing
    send(CMD_FRAME, 32'd12, 8'h42, 8'h00, 16'h0000, 2'd3, 3'd0, 0);     // unknown, other
    send(CMD_FRAME, 32'd13, 8'hFF, 8'h00, 16'h0000, MK_BEAT, 3'd0, 0);  // beat in slave role
    send(CMD_POLL, 32'd100, 8'h00, 8'h00, 16'h0000, 2'd0, 3'd0, 0);     // nothing expires
    send(CMD_POLL, 32'hFFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF, 2'd3, 3'd7, 1); // purge all
    drain();
    write_reg(REG_ROLE, 32'd1);
    write_reg(REG_TIMEOUT, 32'd1);
    send(CMD_LOAD, 32'd20, 8'h21, 8'h00, 16'h0005, 2'd0, 3'd1, 1);
    send(CMD_FRAME, 32'd21, 8'h21, 8'h00, 16'h0005, MK_BEAT, 3'd0, 0);  // comes online
    send(CMD_FRAME, 32'd22, 8'h21, 8'hFF, 16'h0006, MK_BEAT, 3'd0, 0);  // already online
    send(CMD_POLL, 32'd23, 8'h00, 8'h00, 16'h0000, 2'd0, 3'd0, 0);      // exactly timeout
    send(CMD_POLL, 32'd24, 8'h00, 8'h00, 16'h0000, 2'd0, 3'd0, 0);      // goes offline
    send(CMD_FRAME, 32'd30, 8'h21, 8'h00, 16'h0000, MK_BEAT, 3'd0, 0);  // behind, not data
    drain();

    // Master role, tight timeouts.
    write_reg(REG_LOCAL, 32'h12);
    write_reg(REG_TIMEOUT, 32'd50);
    write_reg(REG_HOLD, 32'd100);
    random_phase(90);

    // Zero timeout falls back to the default; zero hold expires at next poll.
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_HOLD, 32'd0);
    write_reg(REG_LOCAL, 32'h00);
    write_reg(REG_BCAST, 32'h00);
    random_phase(90);

    // Slave role, widest values.
    write_reg(REG_ROLE, 32'd0);
    write_reg(REG_LOCAL, 32'hFF);
    write_reg(REG_BCAST, 32'h80);
    write_reg(REG_TIMEOUT, 32'hFFFFFFFF);
    write_reg(REG_HOLD, 32'hFFFFFFFF);
    random_phase(80);

    // Master role again with a long hold so the blacklist fills.
    write_reg(REG_ROLE, 32'hFFFFFFFF);
    write_reg(REG_LOCAL, 32'h5A);
    write_reg(REG_BCAST, 32'hFF);
    write_reg(REG_TIMEOUT, 32'd200);
    write_reg(REG_HOLD, 32'h7FFFFFFF);
    random_phase(80);

    $display("covered %0d input transactions and %0d results over five settings",
             accepted_items, sb.checked);
    $display("frames, poll ticks and loads in both roles, mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[frame_replay_filter_with_blacklist] OK");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0d expected results never arrived", sb.expected_q.size());
      $display("[frame_replay_filter_with_blacklist] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/frf_pkg.sv
design/frf_ctrl.sv
design/frf_dp.sv
design/frame_replay_filter_with_blacklist.sv
test/testbench.sv
